// ===== rtl/core/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg: shared widths, types and helpers of the line/plane intersector
// Holds the coordinate and datapath widths, the divider stream type and the
// register index codes used by every module of the block.
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;

    // Coordinates use at most the 16 bits of their slot.
    localparam int CW   = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int SLOT = 16;
    localparam int VW   = 48;
    localparam int OW   = 32;

    localparam int DW   = CW + 1;          // coordinate differences
    localparam int NW   = 2 * DW + 1;      // normal components
    localparam int PW   = NW + DW;         // normal times difference
    localparam int SW   = PW + 2;          // sum of three products
    localparam int MPW  = DW + SW;         // |p| * |num|
    localparam int DPW  = MPW + FRAC_BITS; // scaled dividend

    localparam int LIMIT_EXP = 40;          // quotient clamps at 2^40
    localparam int QN        = LIMIT_EXP + 1;
    localparam int DVW  = (DPW > QN + 1) ? DPW : QN + 1;
    localparam int HW   = DVW - QN;
    localparam int CMPW = (HW > SW) ? HW : SW;
    localparam int RSW  = QN + 2;           // signed rounded term
    localparam int MSW  = CW + FRAC_BITS;
    localparam int RESW = ((RSW > MSW) ? RSW : MSW) + 2;

    localparam int NCELL = QN;

    localparam logic [QN:0] Q_LIMIT = (QN + 1)'(1) << LIMIT_EXP;
    localparam logic signed [RESW-1:0] RES_MAX = RESW'(64'sd2147483647);
    localparam logic signed [RESW-1:0] RES_MIN = -RES_MAX - RESW'(1);
    localparam logic signed [OW-1:0]   OUT_MAX = OW'(RES_MAX);
    localparam logic signed [OW-1:0]   OUT_MIN = OW'(RES_MIN);

    localparam int IW = 2;
    localparam logic [IW-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [IW-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [IW-1:0] REG_VERTEX_C = 2'd2;

    typedef struct packed {
        logic [SW-1:0]        rem;
        logic [QN-1:0]        low;
        logic [QN-1:0]        quo;
        logic                 ovf;
        logic                 neg;
        logic signed [CW-1:0] m;
    } t_lane;

    typedef struct packed {
        t_lane [2:0]   lane;
        logic [SW-1:0] den;
        logic          no_hit;
    } t_div;

    function automatic logic signed [CW-1:0] slot_coord(input logic [VW-1:0] v,
                                                         input int k);
        return v[SLOT*k +: CW];
    endfunction

endpackage

// ===== rtl/core/lpi_front.sv =====
// ----------------------------------------------------------------------------
// lpi_front: plane setup and dividend preparation
// Five stages: edge products, normal and dot products, sums, magnitudes and
// scaled dividends, then the overflow check that seeds the divider chain.
// ----------------------------------------------------------------------------
module lpi_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [lpi_pkg::VW-1:0]   i_vertex_a,
    input  logic [lpi_pkg::VW-1:0]   i_vertex_b,
    input  logic [lpi_pkg::VW-1:0]   i_vertex_c,
    input  logic signed [15:0]       i_start_x,
    input  logic signed [15:0]       i_start_y,
    input  logic signed [15:0]       i_start_z,
    input  logic signed [15:0]       i_finish_x,
    input  logic signed [15:0]       i_finish_y,
    input  logic signed [15:0]       i_finish_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output lpi_pkg::t_div            o_data
);
    localparam int CW  = lpi_pkg::CW;
    localparam int DW  = lpi_pkg::DW;
    localparam int NW  = lpi_pkg::NW;
    localparam int PW  = lpi_pkg::PW;
    localparam int SW  = lpi_pkg::SW;
    localparam int MPW = lpi_pkg::MPW;
    localparam int DVW = lpi_pkg::DVW;
    localparam int QN  = lpi_pkg::QN;
    localparam int CMPW = lpi_pkg::CMPW;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [CW-1:0] a_c [3];
    logic signed [CW-1:0] b_c [3];
    logic signed [CW-1:0] c_c [3];
    logic signed [CW-1:0] m_c [3];
    logic signed [CW-1:0] f_c [3];
    logic signed [DW-1:0] e1 [3];
    logic signed [DW-1:0] e2 [3];
    logic signed [2*DW-1:0] n_prod [6];

    logic signed [2*DW-1:0] r1_prod [6];
    logic signed [CW-1:0]   r1_m [3];
    logic signed [DW-1:0]   r1_p [3];
    logic signed [DW-1:0]   r1_am [3];

    logic signed [NW-1:0]   nrm [3];
    logic signed [PW-1:0]   r2_np [3];
    logic signed [PW-1:0]   r2_na [3];
    logic signed [CW-1:0]   r2_m [3];
    logic signed [DW-1:0]   r2_p [3];

    logic signed [SW-1:0]   r3_num, r3_den;
    logic signed [CW-1:0]   r3_m [3];
    logic signed [DW-1:0]   r3_p [3];

    logic [SW-1:0]          num_mag, den_mag;
    logic [DW-1:0]          p_mag [3];
    logic [MPW-1:0]         prod [3];
    logic [DVW-1:0]         r4_dv [3];
    logic [SW-1:0]          r4_den;
    logic                   r4_neg [3];
    logic signed [CW-1:0]   r4_m [3];
    logic                   r4_no_hit;

    logic [CMPW-1:0]        hi_ext [3];
    lpi_pkg::t_div          n_data, r5_data;

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v5;
    assign o_data  = r5_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage 1: edge vectors and the six cross-product terms.
    always_comb begin
        m_c[0] = i_start_x[CW-1:0];
        m_c[1] = i_start_y[CW-1:0];
        m_c[2] = i_start_z[CW-1:0];
        f_c[0] = i_finish_x[CW-1:0];
        f_c[1] = i_finish_y[CW-1:0];
        f_c[2] = i_finish_z[CW-1:0];
        for (int k = 0; k < 3; k++) begin
            a_c[k] = lpi_pkg::slot_coord(i_vertex_a, k);
            b_c[k] = lpi_pkg::slot_coord(i_vertex_b, k);
            c_c[k] = lpi_pkg::slot_coord(i_vertex_c, k);
            e1[k]  = DW'(b_c[k]) - DW'(a_c[k]);
            e2[k]  = DW'(c_c[k]) - DW'(a_c[k]);
        end
        n_prod[0] = e1[1] * e2[2];
        n_prod[1] = e2[1] * e1[2];
        n_prod[2] = e1[0] * e2[2];
        n_prod[3] = e2[0] * e1[2];
        n_prod[4] = e1[0] * e2[1];
        n_prod[5] = e2[0] * e1[1];
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r1_prod <= n_prod;
            for (int k = 0; k < 3; k++) begin
                r1_m[k]  <= m_c[k];
                r1_p[k]  <= DW'(f_c[k]) - DW'(m_c[k]);
                r1_am[k] <= DW'(a_c[k]) - DW'(m_c[k]);
            end
        end
    end

    // Stage 2: normal components and their dot products.
    always_comb begin
        nrm[0] = NW'(r1_prod[0]) - NW'(r1_prod[1]);
        nrm[1] = NW'(r1_prod[3]) - NW'(r1_prod[2]);
        nrm[2] = NW'(r1_prod[4]) - NW'(r1_prod[5]);
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            for (int k = 0; k < 3; k++) begin
                r2_np[k] <= nrm[k] * r1_p[k];
                r2_na[k] <= nrm[k] * r1_am[k];
                r2_m[k]  <= r1_m[k];
                r2_p[k]  <= r1_p[k];
            end
        end
    end

    // Stage 3: numerator and denominator sums.
    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r3_num <= SW'(r2_na[0]) + SW'(r2_na[1]) + SW'(r2_na[2]);
            r3_den <= SW'(r2_np[0]) + SW'(r2_np[1]) + SW'(r2_np[2]);
            r3_m   <= r2_m;
            r3_p   <= r2_p;
        end
    end

    // Stage 4: sign-magnitude split and the scaled dividend of each axis.
    always_comb begin
        num_mag = r3_num[SW-1] ? SW'(-r3_num) : SW'(r3_num);
        den_mag = r3_den[SW-1] ? SW'(-r3_den) : SW'(r3_den);
        for (int k = 0; k < 3; k++) begin
            p_mag[k] = r3_p[k][DW-1] ? DW'(-r3_p[k]) : DW'(r3_p[k]);
            prod[k]  = MPW'(p_mag[k]) * MPW'(num_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            for (int k = 0; k < 3; k++) begin
                r4_dv[k]  <= DVW'(prod[k]) << lpi_pkg::FRAC_BITS;
                r4_neg[k] <= r3_p[k][DW-1] ^ r3_num[SW-1] ^ r3_den[SW-1];
                r4_m[k]   <= r3_m[k];
            end
            r4_den    <= den_mag;
            r4_no_hit <= (r3_den == '0);
        end
    end

    // Stage 5: a quotient of 2^41 or more clamps; otherwise the high part
    // of the dividend is already below the divisor and seeds the remainder.
    always_comb begin
        n_data.den    = r4_den;
        n_data.no_hit = r4_no_hit;
        for (int k = 0; k < 3; k++) begin
            hi_ext[k]             = CMPW'(r4_dv[k][DVW-1:QN]);
            n_data.lane[k].ovf    = (hi_ext[k] >= CMPW'(r4_den));
            n_data.lane[k].rem    = SW'(hi_ext[k]);
            n_data.lane[k].low    = r4_dv[k][QN-1:0];
            n_data.lane[k].quo    = '0;
            n_data.lane[k].neg    = r4_neg[k];
            n_data.lane[k].m      = r4_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && rdy5) begin
            r5_data <= n_data;
        end
    end

endmodule

// ===== rtl/core/lpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// lpi_div_cell: one restoring division step for the three axes
// Shifts in the next dividend bit, subtracts the divisor where it fits and
// appends one quotient bit, then hands the beat to the next cell.
// ----------------------------------------------------------------------------
module lpi_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lpi_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lpi_pkg::t_div o_data
);
    localparam int SW = lpi_pkg::SW;
    localparam int QN = lpi_pkg::QN;

    logic          r_valid;
    lpi_pkg::t_div r_data, n_data;
    logic [SW:0]   trial [3];
    logic          qbit [3];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 3; k++) begin
            trial[k] = {i_data.lane[k].rem, i_data.lane[k].low[QN-1]};
            qbit[k]  = (trial[k] >= {1'b0, i_data.den});
            if (qbit[k]) begin
                n_data.lane[k].rem = SW'(trial[k] - {1'b0, i_data.den});
            end else begin
                n_data.lane[k].rem = trial[k][SW-1:0];
            end
            n_data.lane[k].low = {i_data.lane[k].low[QN-2:0], 1'b0};
            n_data.lane[k].quo = {i_data.lane[k].quo[QN-2:0], qbit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== rtl/core/lpi_back.sv =====
// ----------------------------------------------------------------------------
// lpi_back: rounding, clamping and saturation of the intersection point
// Rounds each quotient to nearest, applies the sign, adds the start point in
// fixed point and saturates to 32 bits in the output register.
// ----------------------------------------------------------------------------
module lpi_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  lpi_pkg::t_div              i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [lpi_pkg::OW-1:0] o_hit_x,
    output logic signed [lpi_pkg::OW-1:0] o_hit_y,
    output logic signed [lpi_pkg::OW-1:0] o_hit_z,
    output logic                       o_no_hit,
    output logic                       o_clipped
);
    localparam int QN   = lpi_pkg::QN;
    localparam int CW   = lpi_pkg::CW;
    localparam int RSW  = lpi_pkg::RSW;
    localparam int RESW = lpi_pkg::RESW;
    localparam int OW   = lpi_pkg::OW;

    logic r_v1, r_v2, rdy1, rdy2;

    logic                   rbit [3];
    logic [QN:0]            qr [3];
    logic [QN:0]            qc [3];
    logic [RSW-1:0]         qmag [3];
    logic signed [RSW-1:0]  term [3];

    logic signed [RSW-1:0]  r_term [3];
    logic signed [CW-1:0]   r_m [3];
    logic                   r_nh;

    logic signed [RESW-1:0] mx [3];
    logic signed [RESW-1:0] res [3];
    logic signed [OW-1:0]   sat [3];
    logic                   clip [3];

    logic signed [OW-1:0]   r_hit [3];
    logic                   r_no_hit, r_clipped;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_hit_x = r_hit[0];
    assign o_hit_y = r_hit[1];
    assign o_hit_z = r_hit[2];
    assign o_no_hit  = r_no_hit;
    assign o_clipped = r_clipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // Ties round away from zero: round up when twice the remainder reaches
    // the divisor.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rbit[k] = ({i_data.lane[k].rem, 1'b0} >= {1'b0, i_data.den});
            qr[k]   = {1'b0, i_data.lane[k].quo} + (QN + 1)'(rbit[k]);
            if (i_data.lane[k].ovf || qr[k] > lpi_pkg::Q_LIMIT) begin
                qc[k] = lpi_pkg::Q_LIMIT;
            end else begin
                qc[k] = qr[k];
            end
            qmag[k] = RSW'(qc[k]);
            term[k] = i_data.lane[k].neg ? -qmag[k] : qmag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_term <= term;
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= i_data.lane[k].m;
            end
            r_nh <= i_data.no_hit;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mx[k]  = RESW'(r_m[k]);
            res[k] = (mx[k] <<< lpi_pkg::FRAC_BITS) + RESW'(r_term[k]);
            priority if (res[k] > lpi_pkg::RES_MAX) begin
                sat[k]  = lpi_pkg::OUT_MAX;
                clip[k] = 1'b1;
            end else if (res[k] < lpi_pkg::RES_MIN) begin
                sat[k]  = lpi_pkg::OUT_MIN;
                clip[k] = 1'b1;
            end else begin
                sat[k]  = OW'(res[k]);
                clip[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            for (int k = 0; k < 3; k++) begin
                r_hit[k] <= r_nh ? '0 : sat[k];
            end
            r_no_hit  <= r_nh;
            r_clipped <= !r_nh && (clip[0] || clip[1] || clip[2]);
        end
    end

endmodule

// ===== rtl/core/line_triangle_plane_intersect.sv =====
// ----------------------------------------------------------------------------
// line_triangle_plane_intersect: line versus triangle-plane intersection
// Intersects each input line with the plane through three vertices.
// ----------------------------------------------------------------------------
// Usage:
// The three vertices are written through i_cfg_we/i_cfg_index/i_cfg_data
// while no line is in flight; index values above the third vertex are
// ignored. Each input beat (i_valid/o_ready) carries a line as start and
// finish points; each output beat (o_valid/i_ready) carries the hit point
// in signed Q24.8 with the no_hit and clipped flags, one beat per line, in
// order.
// The pipeline has five setup stages, a chain of 41 division cells
// producing one quotient bit each, and two rounding and saturation
// stages. Throughput is one line per cycle while the receiver does not
// stall, set by the divider chain, which holds one line in every cell.
// Every stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so a stalled receiver fills the pipeline bubble by
// bubble before o_ready drops. Reset clears the vertices and all valid bits.
// ----------------------------------------------------------------------------
module line_triangle_plane_intersect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpi_pkg::IW-1:0]        i_cfg_index,
    input  logic [lpi_pkg::VW-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_start_z,
    input  logic signed [15:0]            i_finish_x,
    input  logic signed [15:0]            i_finish_y,
    input  logic signed [15:0]            i_finish_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [lpi_pkg::OW-1:0] o_hit_x,
    output logic signed [lpi_pkg::OW-1:0] o_hit_y,
    output logic signed [lpi_pkg::OW-1:0] o_hit_z,
    output logic                          o_no_hit,
    output logic                          o_clipped
);
    localparam int NCELL = lpi_pkg::NCELL;

    logic [lpi_pkg::VW-1:0] r_vertex_a, r_vertex_b, r_vertex_c;

    logic          c_valid [NCELL+1];
    logic          c_ready [NCELL+1];
    lpi_pkg::t_div c_data  [NCELL+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_a <= '0;
            r_vertex_b <= '0;
            r_vertex_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpi_pkg::REG_VERTEX_A: r_vertex_a <= i_cfg_data;
                lpi_pkg::REG_VERTEX_B: r_vertex_b <= i_cfg_data;
                lpi_pkg::REG_VERTEX_C: r_vertex_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lpi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_vertex_a (r_vertex_a),
        .i_vertex_b (r_vertex_b),
        .i_vertex_c (r_vertex_c),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_start_z  (i_start_z),
        .i_finish_x (i_finish_x),
        .i_finish_y (i_finish_y),
        .i_finish_z (i_finish_z),
        .o_valid    (c_valid[0]),
        .i_ready    (c_ready[0]),
        .o_data     (c_data[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        lpi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    lpi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_valid[NCELL]),
        .o_ready   (c_ready[NCELL]),
        .i_data    (c_data[NCELL]),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_hit_x   (o_hit_x),
        .o_hit_y   (o_hit_y),
        .o_hit_z   (o_hit_z),
        .o_no_hit  (o_no_hit),
        .o_clipped (o_clipped)
    );

endmodule

// ===== rtl/core/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// lpi_checker: port-level checks of the intersector
// Watches the output channel for reset behavior, stall holding and the
// consistency of the result flags with the hit coordinates.
// ----------------------------------------------------------------------------
module lpi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [lpi_pkg::OW-1:0] o_hit_x,
    input logic signed [lpi_pkg::OW-1:0] o_hit_y,
    input logic signed [lpi_pkg::OW-1:0] o_hit_z,
    input logic                          o_no_hit,
    input logic                          o_clipped
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat present right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_x) && $stable(o_hit_y)
                                && $stable(o_hit_z) && $stable(o_no_hit)
                                && $stable(o_clipped))
        else $error("stalled output beat changed");

    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_hit |-> o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0
                                && !o_clipped)
        else $error("no_hit beat carries a point or a clip flag");

    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            o_hit_x == lpi_pkg::OUT_MAX || o_hit_x == lpi_pkg::OUT_MIN
            || o_hit_y == lpi_pkg::OUT_MAX || o_hit_y == lpi_pkg::OUT_MIN
            || o_hit_z == lpi_pkg::OUT_MAX || o_hit_z == lpi_pkg::OUT_MIN)
        else $error("clipped beat has no saturated coordinate");

endmodule

bind line_triangle_plane_intersect lpi_checker u_lpi_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_hit_x   (o_hit_x),
    .o_hit_y   (o_hit_y),
    .o_hit_z   (o_hit_z),
    .o_no_hit  (o_no_hit),
    .o_clipped (o_clipped)
);
